FILE: rtl/core/crcwh_pkg.sv
// ----------------------------------------------------------------------------
// crcwh_pkg
// Shared types, constants and CRC-32C fold functions for the word hash.
// ----------------------------------------------------------------------------
package crcwh_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned LengthWidth = 64;
   localparam int unsigned WordBytes   = WordWidth / 8;
   localparam int unsigned LengthBytes = LengthWidth / 8;

   typedef logic [WordWidth-1:0]   word_type;
   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [LengthWidth-1:0] length_type;

   localparam word_type  CrcPoly      = 32'h82f63b78;
   localparam word_type  HashMult     = 32'h805204f3;
   localparam count_type BytesPerWord = CountWidth'(WordBytes);

   // one reflected CRC-32C byte step, no inversion
   function automatic word_type fold_byte(word_type crc, logic [7:0] data_byte);
      word_type c;
      c = crc ^ {{(WordWidth-8){1'b0}}, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // four byte steps, low byte first
   function automatic word_type fold_word(word_type crc, word_type data_word);
      word_type c;
      c = crc;
      for (int k = 0; k < WordBytes; k++) begin
         c = fold_byte(c, data_word[8*k +: 8]);
      end
      return c;
   endfunction

   // eight byte steps over the message length, low byte first
   function automatic word_type fold_length(word_type crc, length_type len);
      word_type c;
      c = crc;
      for (int k = 0; k < LengthBytes; k++) begin
         c = fold_byte(c, len[8*k +: 8]);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/crcwh_req_if.sv
// ----------------------------------------------------------------------------
// crcwh_req_if
// Request channel: one message word per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crcwh_req_if;
   import crcwh_pkg::*;

   logic      valid;
   logic      ready;
   word_type  data_word;
   count_type byte_count;
   logic      last;

   modport source (output valid, output data_word, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input data_word, input byte_count, input last,
                   output ready);
endinterface

FILE: rtl/core/crcwh_rsp_if.sv
// ----------------------------------------------------------------------------
// crcwh_rsp_if
// Response channel: one finished hash per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crcwh_rsp_if;
   import crcwh_pkg::*;

   logic     valid;
   logic     ready;
   word_type hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: rtl/core/crc32c_word_hash.sv
// Timing: a last word's hash passes the input, word fold, length fold and
//   multiply registers in turn, and is held while the response side stalls.
// Throughput: one word per cycle barring response stalls; the word CRC fold
//   and state update form the loop, with length fold and multiply after it.
// Reset: synchronous, clears seed, message state and all stage valid bits.
// ----------------------------------------------------------------------------
// crc32c_word_hash
// CRC-32C over little-endian words with length fold and multiply finish.
// ----------------------------------------------------------------------------
module crc32c_word_hash (
   input  logic                clock,
   input  logic                reset,
   crcwh_req_if.sink           req_if,
   crcwh_rsp_if.source         rsp_if,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  crcwh_pkg::word_type csr_seed
);
   import crcwh_pkg::*;

   // configuration
   word_type   seed_ff, seed_in;

   // input stage
   logic       v0_ff, v0_in;
   word_type   word0_ff, word0_in;
   count_type  count0_ff, count0_in;
   logic       last0_ff, last0_in;

   // message state
   word_type   crc_ff, crc_in;
   length_type len_ff, len_in;
   logic       mid_ff, mid_in;

   // after word fold
   logic       v1_ff, v1_in;
   word_type   crc1_ff, crc1_in;
   length_type len1_ff, len1_in;

   // after length fold
   logic       v2_ff, v2_in;
   word_type   crc2_ff, crc2_in;

   // after multiply
   logic       v3_ff, v3_in;
   word_type   prod3_ff, prod3_in;

   logic       free0, free1, free2, free3;
   logic       accept, fire0, skip;
   count_type  count_eff;
   word_type   masked_word;
   word_type   crc_start, crc_word;
   length_type len_start, len_word;
   word_type   prod_low;

   assign free3  = !v3_ff || rsp_if.ready;
   assign free2  = !v2_ff || free3;
   assign free1  = !v1_ff || free2;
   assign free0  = !v0_ff || free1;
   assign accept = req_if.valid && free0;
   assign fire0  = v0_ff && free1;

   assign req_if.ready      = free0;
   assign csr_ready         = 1'b1;
   assign rsp_if.valid      = v3_ff;
   assign rsp_if.hash_value = prod3_ff ^ (prod3_ff >> 16);

   always_comb begin
      count_eff = (count0_ff > BytesPerWord) ? BytesPerWord : count0_ff;
      for (int k = 0; k < WordBytes; k++) begin
         masked_word[8*k +: 8] = (count_eff > CountWidth'(k)) ? word0_ff[8*k +: 8] : 8'd0;
      end
      crc_start = mid_ff ? crc_ff : seed_ff;
      len_start = mid_ff ? len_ff : '0;
      crc_word  = (count_eff != '0) ? fold_word(crc_start, masked_word) : crc_start;
      len_word  = len_start + LengthWidth'(count_eff);
      skip      = (count_eff == '0) && !last0_ff;
      prod_low  = crc2_ff * HashMult;
   end

   always_comb begin
      seed_in   = csr_valid ? csr_seed : seed_ff;

      v0_in     = free0 ? req_if.valid : v0_ff;
      word0_in  = accept ? req_if.data_word  : word0_ff;
      count0_in = accept ? req_if.byte_count : count0_ff;
      last0_in  = accept ? req_if.last       : last0_ff;

      crc_in = crc_ff;
      len_in = len_ff;
      mid_in = mid_ff;
      if (fire0 && !skip) begin
         if (last0_ff) begin
            crc_in = '0;
            len_in = '0;
            mid_in = 1'b0;
         end else begin
            crc_in = crc_word;
            len_in = len_word;
            mid_in = 1'b1;
         end
      end

      v1_in   = free1 ? (fire0 && last0_ff) : v1_ff;
      crc1_in = free1 ? crc_word : crc1_ff;
      len1_in = free1 ? len_word : len1_ff;

      v2_in   = free2 ? v1_ff : v2_ff;
      crc2_in = free2 ? fold_length(crc1_ff, len1_ff) : crc2_ff;

      v3_in    = free3 ? v2_ff : v3_ff;
      prod3_in = free3 ? prod_low : prod3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         v0_ff   <= 1'b0;
         crc_ff  <= '0;
         len_ff  <= '0;
         mid_ff  <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         seed_ff <= seed_in;
         v0_ff   <= v0_in;
         crc_ff  <= crc_in;
         len_ff  <= len_in;
         mid_ff  <= mid_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      word0_ff  <= word0_in;
      count0_ff <= count0_in;
      last0_ff  <= last0_in;
      crc1_ff   <= crc1_in;
      len1_ff   <= len1_in;
      crc2_ff   <= crc2_in;
      prod3_ff  <= prod3_in;
   end

endmodule

FILE: rtl/core/crcwh_checker.sv
// ----------------------------------------------------------------------------
// crcwh_checker
// Port-level checks for the word hash, bound to crc32c_word_hash.
// ----------------------------------------------------------------------------
module crcwh_checker (
   input  logic                clock,
   input  logic                reset,
   crcwh_req_if.sink           req_if,
   crcwh_rsp_if.source         rsp_if,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  crcwh_pkg::word_type csr_seed
);
   import crcwh_pkg::*;

   // last items accepted whose hash is not yet taken
   logic [2:0] pending_ff, pending_in;
   logic       last_in_fire, rsp_fire;

   assign last_in_fire = req_if.valid && req_if.ready && req_if.last;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;

   always_comb begin
      pending_in = pending_ff + 3'(last_in_fire) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.hash_value))
      else $error("stalled hash changed or dropped");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("hash valid right after reset");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> pending_ff != 3'd0)
      else $error("hash without a last word");

   a_req_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_if.valid || rsp_if.ready) |-> req_if.ready && csr_ready)
      else $error("input stalled while output side is free");

   a_csr_known: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> !$isunknown(csr_seed))
      else $error("seed write with unknown data");

endmodule

bind crc32c_word_hash crcwh_checker u_crcwh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_if    (req_if),
   .rsp_if    (rsp_if),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_seed  (csr_seed)
);

FILE: dv/crc32c_word_hash_tb.sv
// ----------------------------------------------------------------------------
// crc32c_word_hash_tb
// Self-checking bench for the CRC-32C word hash. A directed table walks the
// empty message, short and oversized byte counts, ignored empty words and
// data extremes. Random messages then run under several seeds and several
// handshake profiles. Each finished hash is compared with a pinned value or
// a local model of the CRC fold, the length fold and the multiply finish.
// ----------------------------------------------------------------------------
module crc32c_word_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import crcwh_pkg::*;

   typedef struct packed {
      word_type  data_word;
      count_type byte_count;
      logic      last;
      logic      pinned;
      word_type  hash;
   } stim_row_type;

   localparam int unsigned NumRows   = 23;
   localparam int unsigned NumPhases = 5;
   localparam int unsigned PhaseWords = 285;
   localparam int unsigned FlushCycles = 8;

   // pinned rows carry a hash that is known by inspection (seed 0, no bytes)
   stim_row_type directed_rows [NumRows] = '{
      '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
      '{32'hdeadbeef, 3'd0, 1'b0, 1'b0, 32'h00000000},
      '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
      '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h00000000},
      '{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h00000000},
      '{32'h04030201, 3'd1, 1'b0, 1'b0, 32'h00000000},
      '{32'h08070605, 3'd2, 1'b0, 1'b0, 32'h00000000},
      '{32'h0c0b0a09, 3'd3, 1'b1, 1'b0, 32'h00000000},
      '{32'hffffffff, 3'd5, 1'b1, 1'b0, 32'h00000000},
      '{32'h12345678, 3'd6, 1'b0, 1'b0, 32'h00000000},
      '{32'h9abcdef0, 3'd7, 1'b1, 1'b0, 32'h00000000},
      '{32'hcafef00d, 3'd4, 1'b0, 1'b0, 32'h00000000},
      '{32'h00000000, 3'd0, 1'b1, 1'b0, 32'h00000000},
      '{32'h11111111, 3'd4, 1'b0, 1'b0, 32'h00000000},
      '{32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h00000000},
      '{32'h22222222, 3'd4, 1'b1, 1'b0, 32'h00000000},
      '{32'ha5a5a5a5, 3'd3, 1'b1, 1'b0, 32'h00000000},
      '{32'h5a5a5a5a, 3'd2, 1'b1, 1'b0, 32'h00000000},
      '{32'h80000000, 3'd4, 1'b0, 1'b0, 32'h00000000},
      '{32'h00000001, 3'd4, 1'b0, 1'b0, 32'h00000000},
      '{32'h7fffffff, 3'd1, 1'b1, 1'b0, 32'h00000000},
      '{32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h00000000},
      '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h00000000}
   };

   int unsigned send_pct  [NumPhases] = '{0, 85, 0, 28, 0};
   int unsigned stall_pct [NumPhases] = '{0, 0, 85, 28, 0};

   logic     clock;
   logic     reset;
   logic     csr_valid;
   logic     csr_ready;
   word_type csr_seed;

   crcwh_req_if req_bus ();
   crcwh_rsp_if rsp_bus ();

   crc32c_word_hash u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_seed  (csr_seed)
   );

   // model state
   word_type   model_seed;
   word_type   model_crc;
   length_type model_len;
   logic       model_open;

   word_type    hash_expected [$];
   logic        row_pinned;
   word_type    row_hash;
   int unsigned send_idle;
   int unsigned recv_stall;
   int unsigned fail_count;
   int unsigned word_count;
   int unsigned hash_count;
   int unsigned seed_count;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic word_type crc_byte(word_type c, logic [7:0] b);
      word_type r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
   endfunction

   task automatic hash_word(word_type w, count_type cnt_in, logic lst, logic pin,
                            word_type pin_hash);
      count_type  n;
      word_type   c;
      length_type len;
      word_type   prod;
      n = (cnt_in > BytesPerWord) ? BytesPerWord : cnt_in;
      if (n != 0 || lst) begin
         word_count++;
         c   = model_open ? model_crc : model_seed;
         len = model_open ? model_len : '0;
         if (n != 0) begin
            for (int k = 0; k < 4; k++) begin
               c = crc_byte(c, (k < n) ? w[8*k +: 8] : 8'h00);
            end
            len = len + length_type'(n);
         end
         if (lst) begin
            for (int k = 0; k < 8; k++) begin
               c = crc_byte(c, len[8*k +: 8]);
            end
            prod = c * HashMult;
            hash_expected.push_back(pin ? pin_hash : (prod ^ (prod >> 16)));
            model_crc  = '0;
            model_len  = '0;
            model_open = 1'b0;
         end else begin
            model_crc  = c;
            model_len  = len;
            model_open = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         model_seed = '0;
         model_crc  = '0;
         model_len  = '0;
         model_open = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            hash_count++;
            if (hash_expected.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected hash, expected none, actual %h",
                        $time, rsp_bus.hash_value);
            end else if (hash_expected[0] !== rsp_bus.hash_value) begin
               fail_count++;
               $display("%0t: hash_value mismatch, expected %h, actual %h",
                        $time, hash_expected[0], rsp_bus.hash_value);
               void'(hash_expected.pop_front());
            end else begin
               void'(hash_expected.pop_front());
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            hash_word(req_bus.data_word, req_bus.byte_count, req_bus.last,
                      row_pinned, row_hash);
         end
         if (csr_valid && csr_ready) begin
            model_seed = csr_seed;
         end
      end
   end

   task automatic drive_word(word_type w, count_type cnt, logic lst, logic pin,
                             word_type pin_hash);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_word  <= w;
      req_bus.byte_count <= cnt;
      req_bus.last       <= lst;
      row_pinned         <= pin;
      row_hash           <= pin_hash;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (hash_expected.size() != 0);
   endtask

   task automatic write_seed(word_type value);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seed_count++;
   endtask

   task automatic run_phase(int unsigned words_wanted);
      int unsigned sent;
      int unsigned msgs;
      int unsigned n_words;
      int unsigned pick;
      count_type   cnt;
      sent = 0;
      msgs = 0;
      while (sent < words_wanted) begin
         n_words = ($urandom_range(15) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         for (int unsigned k = 1; k <= n_words; k++) begin
            if (k == n_words) begin
               cnt = count_type'($urandom_range(7));
               drive_word($urandom, cnt, 1'b1, 1'b0, '0);
               sent++;
            end else begin
               pick = $urandom_range(19);
               if (pick == 0) begin
                  cnt = '0;
               end else if (pick <= 2) begin
                  cnt = count_type'($urandom_range(3, 1));
               end else if (pick == 3) begin
                  cnt = count_type'($urandom_range(7, 5));
               end else begin
                  cnt = BytesPerWord;
               end
               drive_word($urandom, cnt, 1'b0, 1'b0, '0);
               sent++;
            end
         end
         msgs++;
         if (msgs % 40 == 0) drain();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_word  = '0;
      req_bus.byte_count = '0;
      req_bus.last       = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_valid          = 1'b0;
      csr_seed           = '0;
      row_pinned         = 1'b0;
      row_hash           = '0;
      send_idle          = 0;
      recv_stall         = 0;
      fail_count         = 0;
      word_count         = 0;
      hash_count         = 0;
      seed_count         = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         drive_word(directed_rows[i].data_word, directed_rows[i].byte_count,
                    directed_rows[i].last, directed_rows[i].pinned, directed_rows[i].hash);
      end

      for (int p = 0; p < NumPhases; p++) begin
         drain();
         repeat (FlushCycles) @(posedge clock);
         send_idle  = send_pct[p];
         recv_stall = stall_pct[p];
         case (p)
            0:       write_seed(32'hffffffff);
            2:       write_seed(32'h00000000);
            default: write_seed($urandom);
         endcase
         run_phase(PhaseWords);
      end

      drain();
      repeat (2 * FlushCycles) @(posedge clock);
      $display("Hashed %0d words into %0d checked results under %0d seed settings,",
               word_count, hash_count, seed_count);
      $display("with sender idling and receiver stalling from none up to 85%% of cycles.");
      if (fail_count == 0) begin
         $display("crc32c_word_hash regression: pass");
      end else begin
         $display("crc32c_word_hash regression: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d hashes still outstanding.", hash_expected.size());
      $display("crc32c_word_hash regression: fail");
      $finish;
   end

endmodule
